// ----- design/timed_priority_task_dispatcher_unit_defines.svh -----
// Assertion macros shared by the dispatcher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TIMED_PRIORITY_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define TIMED_PRIORITY_TASK_DISPATCHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TPD_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TPD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tptd_pkg.sv -----
// Shared types and constants of the task dispatcher.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package tptd_pkg;

    // default table depth and results per tick
    localparam int TASK_SLOTS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W         = 3;

    // request codes
    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_REPORT   = 2'd3
    } t_req;

    // result kinds
    localparam logic KIND_REPLY    = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic do_reg;
        logic do_remove;
        logic do_report;
        logic scan_init;
        logic scan_restart;
        logic scan_step;
        logic load_pending;
        logic emit;
        logic emit_last;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        t_req req;
        logic scan_done;
        logic found;
        logic pend_valid;
        logic count_at_max;
    } t_status;

endpackage

// ----- design/timed_priority_task_dispatcher_unit.sv -----
// Timed priority task dispatcher: table of task slots served by priority on each tick.
// Channels: an item (request) is taken when start is high and busy is low. Its fields
//   select register, remove, tick or report. Results come out on the o_ ports for one
//   cycle each, flagged by o_valid; o_last marks the final result of an item.
// Register: one reply (granted slot or table full), registered out of the execute state;
//   busy is high for one cycle, and no new item is taken while busy is high.
// Remove and report: no result, same busy occupancy as register.
// Tick: the slot table is walked one slot per cycle, one pass per dispatched task plus
//   a final pass that finds nothing (or a flush state when the per-tick cap is reached).
//   Each pass uses the single priority/time comparator in the scan. A result is
//   released when the following pass ends, except at the per-tick cap, where the
//   final result goes out in the flush state, in the cycle after the result before it.
// Reset (synchronous, active low) empties the table and drops any tick in progress.
// The receiver cannot stall: every o_valid cycle is one accepted result.
// Depends on tptd_pkg, tptd_ctrl and tptd_datapath.
`timescale 1ns / 1ps

module timed_priority_task_dispatcher_unit #(
    parameter int TASK_SLOTS = tptd_pkg::TASK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_slot,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [7:0]  i_group,
    input  logic [15:0] i_context_tag,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_wake_ms,
    input  logic        i_finished,
    output logic        o_valid,
    output logic        o_kind,
    output logic [2:0]  o_out_slot,
    output logic        o_table_full,
    output logic [7:0]  o_out_task_id,
    output logic [7:0]  o_out_group,
    output logic [15:0] o_out_tag,
    output logic        o_last
);
    import tptd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    tptd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // table and scan datapath
    tptd_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_req_type     (i_req_type),
        .i_slot         (i_slot),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .i_group        (i_group),
        .i_context_tag  (i_context_tag),
        .i_now_ms       (i_now_ms),
        .i_wake_ms      (i_wake_ms),
        .i_finished     (i_finished),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_out_slot     (o_out_slot),
        .o_table_full   (o_table_full),
        .o_out_task_id  (o_out_task_id),
        .o_out_group    (o_out_group),
        .o_out_tag      (o_out_tag),
        .o_last         (o_last)
    );

endmodule

// ----- design/tptd_ctrl.sv -----
// Sequencing state machine of the task dispatcher.
// Depends on tptd_pkg for the command and status structs.
`timescale 1ns / 1ps

module tptd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  tptd_pkg::t_status i_status,
    output tptd_pkg::t_cmd    o_cmd
);
    import tptd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_status.req)
                    REQ_REGISTER: begin
                        o_cmd.do_reg = 1'b1;
                        n_state      = S_IDLE;
                    end
                    REQ_REMOVE: begin
                        o_cmd.do_remove = 1'b1;
                        n_state         = S_IDLE;
                    end
                    REQ_REPORT: begin
                        o_cmd.do_report = 1'b1;
                        n_state         = S_IDLE;
                    end
                    REQ_TICK: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            // a pass has finished: hold the winner back until we know if it is the last
            S_DECIDE: begin
                if (i_status.found) begin
                    o_cmd.load_pending = 1'b1;
                    o_cmd.emit         = i_status.pend_valid;
                    if (i_status.count_at_max) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.scan_restart = 1'b1;
                        n_state            = S_SCAN;
                    end
                end else begin
                    o_cmd.emit      = i_status.pend_valid;
                    o_cmd.emit_last = i_status.pend_valid;
                    n_state         = S_IDLE;
                end
            end
            S_FLUSH: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- design/tptd_datapath.sv -----
// Slot table, ready scan and result registers of the task dispatcher.
// Depends on tptd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "timed_priority_task_dispatcher_unit_defines.svh"

module tptd_datapath #(
    parameter int TASK_SLOTS = tptd_pkg::TASK_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tptd_pkg::t_cmd    i_cmd,
    output tptd_pkg::t_status o_status,
    input  logic [1:0]        i_req_type,
    input  logic [2:0]        i_slot,
    input  logic [7:0]        i_task_id,
    input  logic [7:0]        i_priority_req,
    input  logic [7:0]        i_group,
    input  logic [15:0]       i_context_tag,
    input  logic [31:0]       i_now_ms,
    input  logic [31:0]       i_wake_ms,
    input  logic              i_finished,
    output logic              o_valid,
    output logic              o_kind,
    output logic [2:0]        o_out_slot,
    output logic              o_table_full,
    output logic [7:0]        o_out_task_id,
    output logic [7:0]        o_out_group,
    output logic [15:0]       o_out_tag,
    output logic              o_last
);
    import tptd_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);

    // captured item
    t_req        r_req;
    logic [2:0]  r_slot;
    logic [7:0]  r_task_id;
    logic [7:0]  r_prio;
    logic [7:0]  r_group;
    logic [15:0] r_tag;
    logic [31:0] r_now;
    logic [31:0] r_wake_ms;
    logic        r_fin;

    // slot table
    logic [TASK_SLOTS-1:0] r_valid;
    logic [7:0]            r_slot_id   [TASK_SLOTS];
    logic [7:0]            r_slot_prio [TASK_SLOTS];
    logic [7:0]            r_slot_grp  [TASK_SLOTS];
    logic [15:0]           r_slot_tag  [TASK_SLOTS];
    logic [31:0]           r_slot_wake [TASK_SLOTS];

    // scan state
    logic [TASK_SLOTS-1:0] r_taken;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [7:0]            r_best_prio;
    logic [7:0]            r_best_id;
    logic [7:0]            r_best_grp;
    logic [15:0]           r_best_tag;

    // held winner, not yet emitted
    logic                  r_pend_valid;
    logic [IDX_W-1:0]      r_pend_idx;
    logic [7:0]            r_pend_id;
    logic [7:0]            r_pend_grp;
    logic [15:0]           r_pend_tag;
    logic [CNT_W-1:0]      r_count;

    // output registers
    logic        r_o_valid;
    logic        r_o_kind;
    logic [2:0]  r_o_slot;
    logic        r_o_full;
    logic [7:0]  r_o_task_id;
    logic [7:0]  r_o_group;
    logic [15:0] r_o_tag;
    logic        r_o_last;

    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             cand;
    logic             report_hit;

    // target slot of remove and report
    assign slot_ok    = (32'(r_slot) < 32'(TASK_SLOTS));
    assign slot_idx   = IDX_W'(r_slot);
    assign report_hit = i_cmd.do_report && slot_ok && r_valid[slot_idx];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = TASK_SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    // one slot per cycle: ready, not yet sent, and strictly better than the best so far
    assign cand = r_valid[r_idx] && !r_taken[r_idx] && (r_now >= r_slot_wake[r_idx])
                  && (!r_found || (r_slot_prio[r_idx] > r_best_prio));

    assign o_status.req          = r_req;
    assign o_status.scan_done    = (r_idx == IDX_W'(TASK_SLOTS - 1));
    assign o_status.found        = r_found;
    assign o_status.pend_valid   = r_pend_valid;
    assign o_status.count_at_max = ((r_count + CNT_W'(1)) == CNT_W'(MAX_RESULTS));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_taken      <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.do_reg || i_cmd.emit;
            if (i_cmd.do_reg && free_found) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (i_cmd.do_remove && slot_ok) begin
                r_valid[slot_idx] <= 1'b0;
            end
            if (report_hit && r_fin) begin
                r_valid[slot_idx] <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_taken      <= '0;
                r_pend_valid <= 1'b0;
                r_count      <= '0;
            end
            if (i_cmd.scan_init || i_cmd.scan_restart) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + IDX_W'(1);
                if (cand) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_pending) begin
                r_pend_valid        <= 1'b1;
                r_taken[r_best_idx] <= 1'b1;
                r_count             <= r_count + CNT_W'(1);
            end
        end
    end

    // payload: item capture, table writes, scan winner, held result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= t_req'(i_req_type);
            r_slot    <= i_slot;
            r_task_id <= i_task_id;
            r_prio    <= i_priority_req;
            r_group   <= i_group;
            r_tag     <= i_context_tag;
            r_now     <= i_now_ms;
            r_wake_ms <= i_wake_ms;
            r_fin     <= i_finished;
        end
        if (i_cmd.do_reg && free_found) begin
            r_slot_id[free_idx]   <= r_task_id;
            r_slot_prio[free_idx] <= r_prio;
            r_slot_grp[free_idx]  <= r_group;
            r_slot_tag[free_idx]  <= r_tag;
            r_slot_wake[free_idx] <= '0;
        end
        if (report_hit && !r_fin) begin
            r_slot_wake[slot_idx] <= r_wake_ms;
        end
        if (i_cmd.scan_step && cand) begin
            r_best_idx  <= r_idx;
            r_best_prio <= r_slot_prio[r_idx];
            r_best_id   <= r_slot_id[r_idx];
            r_best_grp  <= r_slot_grp[r_idx];
            r_best_tag  <= r_slot_tag[r_idx];
        end
        if (i_cmd.load_pending) begin
            r_pend_idx <= r_best_idx;
            r_pend_id  <= r_best_id;
            r_pend_grp <= r_best_grp;
            r_pend_tag <= r_best_tag;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_reg) begin
            r_o_kind    <= KIND_REPLY;
            r_o_slot    <= free_found ? 3'(free_idx) : 3'd0;
            r_o_full    <= !free_found;
            r_o_task_id <= '0;
            r_o_group   <= '0;
            r_o_tag     <= '0;
            r_o_last    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_o_kind    <= KIND_DISPATCH;
            r_o_slot    <= 3'(r_pend_idx);
            r_o_full    <= 1'b0;
            r_o_task_id <= r_pend_id;
            r_o_group   <= r_pend_grp;
            r_o_tag     <= r_pend_tag;
            r_o_last    <= i_cmd.emit_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_out_slot    = r_o_slot;
    assign o_table_full  = r_o_full;
    assign o_out_task_id = r_o_task_id;
    assign o_out_group   = r_o_group;
    assign o_out_tag     = r_o_tag;
    assign o_last        = r_o_last;

    // checks
    `TPD_ASSERT_IMPLY(a_reply_single, i_clk, i_rst_n, r_o_valid && (r_o_kind == KIND_REPLY), r_o_last && (r_o_task_id == 8'd0), "registration reply must be a single last item")
    `TPD_ASSERT_NEXT(a_take_new_slot, i_clk, i_rst_n, i_cmd.load_pending, $countones(r_taken) == $past($countones(r_taken)) + 1, "winner was already dispatched on this tick")
    `TPD_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, r_pend_valid, (r_count != '0) && (r_count <= CNT_W'(MAX_RESULTS)), "dispatch count out of range")

endmodule

// ----- test/tptd_checker.sv -----
// Checker for the task dispatcher: keeps its own copy of the slot table, predicts the
// replies and dispatches of every accepted request, and compares them as they come out.
// Depends on tptd_pkg for the request codes, result kinds and per-tick cap.
`timescale 1ns / 1ps

module tptd_checker #(
    parameter int TASK_SLOTS = tptd_pkg::TASK_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  tptd_pkg::t_req i_req_type,
    input  logic [2:0]    i_slot,
    input  logic [7:0]    i_task_id,
    input  logic [7:0]    i_priority_req,
    input  logic [7:0]    i_group,
    input  logic [15:0]   i_context_tag,
    input  logic [31:0]   i_now_ms,
    input  logic [31:0]   i_wake_ms,
    input  logic          i_finished,
    input  logic          i_res_valid,
    input  logic          i_res_kind,
    input  logic [2:0]    i_res_slot,
    input  logic          i_res_full,
    input  logic [7:0]    i_res_task_id,
    input  logic [7:0]    i_res_group,
    input  logic [15:0]   i_res_tag,
    input  logic          i_res_last,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);

    // one reply or dispatch as it should appear on the result ports
    typedef struct packed {
        logic        kind;
        logic [2:0]  slot;
        logic        full;
        logic [7:0]  task_id;
        logic [7:0]  grp;
        logic [15:0] tag;
        logic        last;
    } t_result;

    // shadow slot table
    logic        tbl_valid [TASK_SLOTS];
    logic [7:0]  tbl_id    [TASK_SLOTS];
    logic [7:0]  tbl_prio  [TASK_SLOTS];
    logic [7:0]  tbl_group [TASK_SLOTS];
    logic [15:0] tbl_tag   [TASK_SLOTS];
    logic [31:0] tbl_wake  [TASK_SLOTS];

    t_result awaited_results [$];
    int      fail_count = 0;
    int      checked    = 0;

    task automatic flag_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
        end
    endtask

    // update the shadow table for one request and queue the results it causes
    task automatic apply_request(input tptd_pkg::t_req req, input logic [2:0] s,
                                 input logic [7:0] id, input logic [7:0] prio,
                                 input logic [7:0] grp, input logic [15:0] tag,
                                 input logic [31:0] now, input logic [31:0] wake,
                                 input logic fin);
        int      n;
        int      best;
        bit      found;
        bit      done;
        bit      taken [TASK_SLOTS];
        t_result r;
        t_result picks [tptd_pkg::MAX_RESULTS];

        r = '0;
        case (req)
            tptd_pkg::REQ_REGISTER: begin
                // lowest free slot wins, wake time starts at zero
                found = 1'b0;
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (!found && !tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_id[i]    = id;
                        tbl_prio[i]  = prio;
                        tbl_group[i] = grp;
                        tbl_tag[i]   = tag;
                        tbl_wake[i]  = '0;
                        r.slot       = 3'(i);
                        found        = 1'b1;
                    end
                end
                r.kind = tptd_pkg::KIND_REPLY;
                r.full = !found;
                r.last = 1'b1;
                awaited_results.push_back(r);
            end
            tptd_pkg::REQ_REMOVE: begin
                if (s < TASK_SLOTS) begin
                    tbl_valid[s] = 1'b0;
                end
            end
            tptd_pkg::REQ_REPORT: begin
                if (s < TASK_SLOTS && tbl_valid[s]) begin
                    if (fin) begin
                        tbl_valid[s] = 1'b0;
                    end else begin
                        tbl_wake[s] = wake;
                    end
                end
            end
            default: begin
                // tick: pick ready slots by priority, ties to the lower slot
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    taken[i] = 1'b0;
                end
                n    = 0;
                done = 1'b0;
                while (n < tptd_pkg::MAX_RESULTS && !done) begin
                    best = -1;
                    for (int i = 0; i < TASK_SLOTS; i++) begin
                        if (tbl_valid[i] && !taken[i] && now >= tbl_wake[i]) begin
                            if (best < 0 || tbl_prio[i] > tbl_prio[best]) begin
                                best = i;
                            end
                        end
                    end
                    if (best < 0) begin
                        done = 1'b1;
                    end else begin
                        taken[best]      = 1'b1;
                        r                = '0;
                        r.kind           = tptd_pkg::KIND_DISPATCH;
                        r.slot           = 3'(best);
                        r.task_id        = tbl_id[best];
                        r.grp            = tbl_group[best];
                        r.tag            = tbl_tag[best];
                        picks[n]         = r;
                        n++;
                    end
                end
                for (int k = 0; k < n; k++) begin
                    r      = picks[k];
                    r.last = (k == n - 1);
                    awaited_results.push_back(r);
                end
            end
        endcase
    endtask

    // compare one result from the block with the oldest one awaited
    task automatic check_result();
        t_result want;

        if (awaited_results.size() == 0) begin
            flag_mismatch($sformatf("result with nothing awaited: kind %0d slot %0d",
                                    i_res_kind, i_res_slot));
        end else begin
            want = awaited_results.pop_front();
            checked++;
            check_field("kind", 32'(i_res_kind), 32'(want.kind));
            check_field("out_slot", 32'(i_res_slot), 32'(want.slot));
            check_field("table_full", 32'(i_res_full), 32'(want.full));
            check_field("out_task_id", 32'(i_res_task_id), 32'(want.task_id));
            check_field("out_group", 32'(i_res_group), 32'(want.grp));
            check_field("out_tag", 32'(i_res_tag), 32'(want.tag));
            check_field("last", 32'(i_res_last), 32'(want.last));
        end
    endtask

    // sample both channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                tbl_valid[i] = 1'b0;
            end
            awaited_results.delete();
        end else begin
            if (i_res_valid === 1'b1) begin
                check_result();
            end
            if (i_start && !i_busy) begin
                apply_request(i_req_type, i_slot, i_task_id, i_priority_req, i_group,
                              i_context_tag, i_now_ms, i_wake_ms, i_finished);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the dispatcher testbench: clock, reset, request stimulus and the verdict.
// Depends on tptd_pkg, timed_priority_task_dispatcher_unit and tptd_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int TASK_SLOTS  = tptd_pkg::TASK_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 136;
    localparam int SETTLE_CYCLES = 4 * (TASK_SLOTS + 1) + 8;

    logic           i_clk;
    logic           i_rst_n        = 1'b0;
    logic           start          = 1'b0;
    tptd_pkg::t_req req_type       = tptd_pkg::REQ_REGISTER;
    logic [2:0]     slot_sel       = '0;
    logic [7:0]     task_id        = '0;
    logic [7:0]     prio           = '0;
    logic [7:0]     grp            = '0;
    logic [15:0]    ctx_tag        = '0;
    logic [31:0]    now_ms         = '0;
    logic [31:0]    wake_ms        = '0;
    logic           fin            = 1'b0;

    logic           busy;
    logic           res_valid;
    logic           res_kind;
    logic [2:0]     res_slot;
    logic           res_full;
    logic [7:0]     res_task_id;
    logic [7:0]     res_group;
    logic [15:0]    res_tag;
    logic           res_last;

    int             fail_count;
    int             pending;
    int             checked;
    int             items_sent = 0;
    logic [31:0]    sim_ms;

    timed_priority_task_dispatcher_unit #(
        .TASK_SLOTS(TASK_SLOTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (req_type),
        .i_slot        (slot_sel),
        .i_task_id     (task_id),
        .i_priority_req(prio),
        .i_group       (grp),
        .i_context_tag (ctx_tag),
        .i_now_ms      (now_ms),
        .i_wake_ms     (wake_ms),
        .i_finished    (fin),
        .o_valid       (res_valid),
        .o_kind        (res_kind),
        .o_out_slot    (res_slot),
        .o_table_full  (res_full),
        .o_out_task_id (res_task_id),
        .o_out_group   (res_group),
        .o_out_tag     (res_tag),
        .o_last        (res_last)
    );

    tptd_checker #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req_type    (req_type),
        .i_slot        (slot_sel),
        .i_task_id     (task_id),
        .i_priority_req(prio),
        .i_group       (grp),
        .i_context_tag (ctx_tag),
        .i_now_ms      (now_ms),
        .i_wake_ms     (wake_ms),
        .i_finished    (fin),
        .i_res_valid   (res_valid),
        .i_res_kind    (res_kind),
        .i_res_slot    (res_slot),
        .i_res_full    (res_full),
        .i_res_task_id (res_task_id),
        .i_res_group   (res_group),
        .i_res_tag     (res_tag),
        .i_res_last    (res_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // drive one item and hold it until the block takes it; start stays high
    task automatic issue_request(input tptd_pkg::t_req req, input logic [2:0] s,
                                 input logic [7:0] id, input logic [7:0] p,
                                 input logic [7:0] g, input logic [15:0] tag,
                                 input logic [31:0] now, input logic [31:0] wake,
                                 input logic f);
        req_type <= req;
        slot_sel <= s;
        task_id  <= id;
        prio     <= p;
        grp      <= g;
        ctx_tag  <= tag;
        now_ms   <= now;
        wake_ms  <= wake;
        fin      <= f;
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // per-request wrappers; fields the request ignores get random values
    task automatic put_register(input logic [7:0] id, input logic [7:0] p,
                                input logic [7:0] g, input logic [15:0] tag);
        issue_request(tptd_pkg::REQ_REGISTER, 3'($urandom), id, p, g, tag,
                      $urandom, $urandom, 1'($urandom));
    endtask

    task automatic put_remove(input logic [2:0] s);
        issue_request(tptd_pkg::REQ_REMOVE, s, 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), $urandom, $urandom, 1'($urandom));
    endtask

    task automatic put_report(input logic [2:0] s, input logic [31:0] wake, input logic f);
        issue_request(tptd_pkg::REQ_REPORT, s, 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), $urandom, wake, f);
    endtask

    task automatic put_tick(input logic [31:0] now);
        issue_request(tptd_pkg::REQ_TICK, 3'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom), now, $urandom, 1'($urandom));
    endtask

    task automatic pause_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every awaited result has come out
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // one random request, mostly well-formed traffic around a moving clock
    task automatic random_request();
        int          pick;
        logic [7:0]  p;
        logic [31:0] w;

        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // narrow priorities half the time so ties are common
            p = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            put_register(8'($urandom), p, 8'($urandom), 16'($urandom));
        end else if (pick < 55) begin
            put_remove(3'($urandom));
        end else if (pick < 75) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom : sim_ms + $urandom_range(0, 60);
            put_report(3'($urandom), w, $urandom_range(0, 3) == 0);
        end else begin
            sim_ms = sim_ms + $urandom_range(0, 40);
            put_tick(($urandom_range(0, 9) == 0) ? $urandom : sim_ms);
        end
    endtask

    // stimulus and verdict
    initial begin
        int burst;
        int done_random;
        int next_drain;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: tick finds nothing, remove and report of free slots do nothing
        put_tick(32'd0);
        put_remove(3'd3);
        put_report(3'd5, 32'd77, 1'b0);

        // fill every slot with extreme fields and tied priorities
        put_register(8'h00, 8'd5,   8'h00, 16'h0000);
        put_register(8'hFF, 8'd255, 8'hFF, 16'hFFFF);
        put_register(8'h5A, 8'd5,   8'hA5, 16'h5A5A);
        put_register(8'hA5, 8'd0,   8'h5A, 16'hA5A5);
        put_register(8'h01, 8'd200, 8'h80, 16'h8000);
        put_register(8'h80, 8'd255, 8'h01, 16'h0001);
        put_register(8'h7F, 8'd5,   8'h7F, 16'h7FFF);
        put_register(8'hFE, 8'd0,   8'hFE, 16'hFFFE);
        // table full
        put_register(8'h33, 8'd99,  8'h33, 16'h3333);
        // every slot ready: the per-tick cap is reached
        put_tick(32'd0);

        // sleep one slot until FFFF_FFFF, one until 100, end one
        put_report(3'd2, 32'hFFFF_FFFF, 1'b0);
        put_report(3'd4, 32'd100, 1'b0);
        put_report(3'd6, 32'd0, 1'b1);
        put_tick(32'd50);
        put_tick(32'd100);
        put_tick(32'hFFFF_FFFF);

        // freed slots are reused lowest first
        put_remove(3'd0);
        put_remove(3'd7);
        put_register(8'h11, 8'd128, 8'h22, 16'h3344);
        put_register(8'h55, 8'd128, 8'h66, 16'h7788);
        put_tick(32'hFFFF_FFFF);
        drain();

        // random part: bursts with gaps, an occasional full drain
        sim_ms      = $urandom_range(0, 1000);
        done_random = 0;
        next_drain  = 50;
        while (done_random < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++) begin
                random_request();
                done_random++;
            end
            if (done_random >= next_drain) begin
                drain();
                next_drain += 50;
            end else if ($urandom_range(0, 3) != 0) begin
                pause_cycles($urandom_range(1, 12));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (register, remove, report, tick), %0d results checked.",
                 items_sent, checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
